[sv/bds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    // two divider lanes: index 0 is the x4 prescale, index 1 the x16 prescale
    localparam int LANES = 2;
    localparam int LANE_X4 = 0;
    localparam int LANE_X16 = 1;

    localparam int CLK_W = 28;
    localparam int BAUD_W = 22;

    // first chain: rounded divisor, one numerator bit per cell
    localparam int STEPS_A = 29;
    localparam int DEN_A_W = 26;

    // second chain: permille error, quotient never reaches 1024
    localparam int STEPS_B = 10;
    localparam int DEN_B_W = 29;
    localparam int ERR_NUM_W = 36;
    localparam int DIFF_W = 26;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd16000000;
    localparam int ERR_SCALE = 1000;

    // characters per ms: (baud + 5000) / 10000 by reciprocal and one correction
    localparam int BPM_X_W = 23;
    localparam int BPM_PROD_W = 47;
    localparam int BPM_SHIFT = 37;
    localparam int BPM_Q_W = 10;
    localparam int BPM_REM_W = 15;
    localparam logic [23:0] BPM_RECIP = 24'd13743895;
    localparam int BPM_BIAS = 5000;
    localparam int BPM_DIV = 10000;

    typedef struct packed {
        logic [1:0]          port;
        logic                zero;
        logic [BPM_X_W-1:0]  x;
        logic [BPM_Q_W-1:0]  qe;
    } t_side_a;

    typedef struct packed {
        logic [1:0]           port;
        logic                 zero;
        logic                 neg4;
        logic                 neg16;
        logic                 fit4;
        logic [7:0]           d4;
        logic [7:0]           d16;
        logic [BPM_Q_W-1:0]   qe;
        logic [BPM_REM_W-1:0] brem;
    } t_side_b;

endpackage

`default_nettype wire

[sv/bds_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module bds_div_cell
    import bds_pkg::*;
#(
    parameter int STEPS = 2,
    parameter int DEN_W = 2,
    parameter int SIDE_W = 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic [LANES-1:0][DEN_W-1:0]        i_rem,
    input  wire logic [LANES-1:0][STEPS-1:0]        i_num,
    input  wire logic [LANES-1:0][STEPS-1:0]        i_quo,
    input  wire logic [LANES-1:0][DEN_W-1:0]        i_den,
    input  wire logic [SIDE_W-1:0]                  i_side,
    output logic                                    o_valid,
    output logic [LANES-1:0][DEN_W-1:0]             o_rem,
    output logic [LANES-1:0][STEPS-1:0]             o_num,
    output logic [LANES-1:0][STEPS-1:0]             o_quo,
    output logic [LANES-1:0][DEN_W-1:0]             o_den,
    output logic [SIDE_W-1:0]                       o_side
);

    logic [LANES-1:0][DEN_W:0]     w_trial;
    logic [LANES-1:0][DEN_W:0]     w_diff;
    logic [LANES-1:0]              w_ge;
    logic [LANES-1:0][DEN_W-1:0]   n_rem;
    logic [LANES-1:0][STEPS-1:0]   n_num;
    logic [LANES-1:0][STEPS-1:0]   n_quo;

    // one restoring step per lane: shift in the next numerator bit, subtract if it fits
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_trial[l] = {i_rem[l], i_num[l][STEPS-1]};
            w_ge[l] = w_trial[l] >= {1'b0, i_den[l]};
            w_diff[l] = w_trial[l] - {1'b0, i_den[l]};
            n_rem[l] = w_ge[l] ? w_diff[l][DEN_W-1:0] : w_trial[l][DEN_W-1:0];
            n_num[l] = {i_num[l][STEPS-2:0], 1'b0};
            n_quo[l] = {i_quo[l][STEPS-2:0], w_ge[l]};
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_num <= n_num;
            o_quo <= n_quo;
            o_den <= i_den;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

[sv/bds_div_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

module bds_div_chain
    import bds_pkg::*;
#(
    parameter int STEPS = 2,
    parameter int DEN_W = 2,
    parameter int SIDE_W = 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic [LANES-1:0][DEN_W-1:0]        i_rem,
    input  wire logic [LANES-1:0][STEPS-1:0]        i_num,
    input  wire logic [LANES-1:0][DEN_W-1:0]        i_den,
    input  wire logic [SIDE_W-1:0]                  i_side,
    output logic                                    o_valid,
    output logic [LANES-1:0][DEN_W-1:0]             o_rem,
    output logic [LANES-1:0][STEPS-1:0]             o_quo,
    output logic [LANES-1:0][DEN_W-1:0]             o_den,
    output logic [SIDE_W-1:0]                       o_side
);

    logic                              w_valid [STEPS+1];
    logic [LANES-1:0][DEN_W-1:0]       w_rem [STEPS+1];
    logic [LANES-1:0][STEPS-1:0]       w_num [STEPS+1];
    logic [LANES-1:0][STEPS-1:0]       w_quo [STEPS+1];
    logic [LANES-1:0][DEN_W-1:0]       w_den [STEPS+1];
    logic [SIDE_W-1:0]                 w_side [STEPS+1];

    // chain head
    assign w_valid[0] = i_valid;
    assign w_rem[0] = i_rem;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_side[0] = i_side;

    // one cell per quotient bit
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        bds_div_cell #(
            .STEPS(STEPS),
            .DEN_W(DEN_W),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_en(i_en),
            .i_valid(w_valid[g]),
            .i_rem(w_rem[g]),
            .i_num(w_num[g]),
            .i_quo(w_quo[g]),
            .i_den(w_den[g]),
            .i_side(w_side[g]),
            .o_valid(w_valid[g+1]),
            .o_rem(w_rem[g+1]),
            .o_num(w_num[g+1]),
            .o_quo(w_quo[g+1]),
            .o_den(w_den[g+1]),
            .o_side(w_side[g+1])
        );
    end

    // chain tail, the numerator is fully shifted out here
    assign o_valid = w_valid[STEPS];
    assign o_rem = w_rem[STEPS];
    assign o_quo = w_quo[STEPS];
    assign o_den = w_den[STEPS];
    assign o_side = w_side[STEPS];

endmodule

`default_nettype wire

[sv/baud_divisor_selector.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   | valid    | stall    | payload
// ----------+----------+----------+------------------------------------------------
// input     | i_valid  | o_stall  | i_port_number, i_baud_rate
// output    | o_valid  | i_stall  | o_port_tag, o_divisor, o_high_speed,
//           |          |          | o_chars_per_ms, o_range_error
// config    | i_cfg_wr_en (no handshake) | i_cfg_wr_data (clock_hz)
//
// one item per cycle when not stalled; stages: input register, 29 cells of the
// rounded-divisor chain, one prep stage, 10 cells of the error chain, output register.
// the whole pipeline advances together; a stalled output holds every stage.
// synchronous active-low reset clears the valid flags and loads clock_hz = 16000000.

module baud_divisor_selector
    import bds_pkg::*;
#(
    parameter int DIVISOR_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CLK_W-1:0]     i_cfg_wr_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_port_number,
    input  wire logic [BAUD_W-1:0]    i_baud_rate,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [1:0]                o_port_tag,
    output logic [7:0]                o_divisor,
    output logic                      o_high_speed,
    output logic [8:0]                o_chars_per_ms,
    output logic                      o_range_error
);

    localparam int SIDE_A_W = $bits(t_side_a);
    localparam int SIDE_B_W = $bits(t_side_b);
    localparam logic [STEPS_A-1:0] FIT_MAX = STEPS_A'(1) << DIVISOR_BITS;

    logic w_adv;
    logic [CLK_W-1:0] r_clock_hz;

    // pipeline moves when the output register is free or being drained
    assign w_adv = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // clock frequency register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLK_RESET;
        end else if (i_cfg_wr_en) begin
            r_clock_hz <= i_cfg_wr_data;
        end
    end

    // input register
    logic              r_s0_valid;
    logic [1:0]        r_s0_port;
    logic [BAUD_W-1:0] r_s0_baud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_port <= i_port_number;
            r_s0_baud <= i_baud_rate;
        end
    end

    // rounded numerators and prescaled denominators, plus reciprocal product
    logic [LANES-1:0][DEN_A_W-1:0]  w_a_rem;
    logic [LANES-1:0][STEPS_A-1:0]  w_a_num;
    logic [LANES-1:0][DEN_A_W-1:0]  w_a_den;
    logic [BPM_X_W-1:0]             w_x;
    logic [BPM_PROD_W-1:0]          w_prod;
    t_side_a                        w_side_a;

    always_comb begin
        w_a_rem = '0;
        w_a_num[LANE_X4] = {1'b0, r_clock_hz} + {6'b0, r_s0_baud, 1'b0};
        w_a_num[LANE_X16] = {1'b0, r_clock_hz} + {4'b0, r_s0_baud, 3'b0};
        w_a_den[LANE_X4] = {2'b0, r_s0_baud, 2'b0};
        w_a_den[LANE_X16] = {r_s0_baud, 4'b0};
        w_x = {1'b0, r_s0_baud} + BPM_X_W'(BPM_BIAS);
        w_prod = BPM_PROD_W'(w_x) * BPM_PROD_W'(BPM_RECIP);
        w_side_a.port = r_s0_port;
        w_side_a.zero = (r_s0_baud == '0);
        w_side_a.x = w_x;
        w_side_a.qe = w_prod[BPM_SHIFT +: BPM_Q_W];
    end

    logic                           w_ao_valid;
    logic [LANES-1:0][DEN_A_W-1:0]  w_ao_rem;
    logic [LANES-1:0][STEPS_A-1:0]  w_ao_quo;
    logic [LANES-1:0][DEN_A_W-1:0]  w_ao_den;
    logic [SIDE_A_W-1:0]            w_ao_side;
    t_side_a                        w_sa;

    bds_div_chain #(
        .STEPS(STEPS_A),
        .DEN_W(DEN_A_W),
        .SIDE_W(SIDE_A_W)
    ) u_chain_a (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(w_adv),
        .i_valid(r_s0_valid),
        .i_rem(w_a_rem),
        .i_num(w_a_num),
        .i_den(w_a_den),
        .i_side(w_side_a),
        .o_valid(w_ao_valid),
        .o_rem(w_ao_rem),
        .o_quo(w_ao_quo),
        .o_den(w_ao_den),
        .o_side(w_ao_side)
    );

    assign w_sa = t_side_a'(w_ao_side);

    // error numerator |r - D/2| * 1000 and denominator clock + D/2 - r
    logic [LANES-1:0][DEN_A_W-1:0]  w_half;
    logic [LANES-1:0][DIFF_W-1:0]   w_absdiff;
    logic [LANES-1:0][ERR_NUM_W-1:0] w_num_e;
    logic [LANES-1:0][DEN_B_W-1:0]  n_p_rem;
    logic [LANES-1:0][STEPS_B-1:0]  n_p_num;
    logic [LANES-1:0][DEN_B_W-1:0]  n_p_den;
    logic [BPM_X_W-1:0]             w_bq;
    logic [BPM_X_W-1:0]             w_bdiff;
    t_side_b                        n_p_side;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_half[l] = w_ao_den[l] >> 1;
            w_absdiff[l] = (w_ao_rem[l] >= w_half[l]) ? (w_ao_rem[l] - w_half[l])
                                                      : (w_half[l] - w_ao_rem[l]);
            w_num_e[l] = ERR_NUM_W'(w_absdiff[l]) * ERR_NUM_W'(ERR_SCALE);
            n_p_rem[l] = DEN_B_W'(w_num_e[l][ERR_NUM_W-1:STEPS_B]);
            n_p_num[l] = w_num_e[l][STEPS_B-1:0];
            n_p_den[l] = {1'b0, r_clock_hz} + DEN_B_W'(w_half[l]) - DEN_B_W'(w_ao_rem[l]);
        end
        w_bq = BPM_X_W'(w_sa.qe) * BPM_X_W'(BPM_DIV);
        w_bdiff = w_sa.x - w_bq;
        n_p_side.port = w_sa.port;
        n_p_side.zero = w_sa.zero;
        n_p_side.neg4 = (w_ao_quo[LANE_X4] == '0);
        n_p_side.neg16 = (w_ao_quo[LANE_X16] == '0);
        n_p_side.fit4 = (w_ao_quo[LANE_X4] <= FIT_MAX);
        n_p_side.d4 = w_ao_quo[LANE_X4][7:0] - 8'd1;
        n_p_side.d16 = w_ao_quo[LANE_X16][7:0] - 8'd1;
        n_p_side.qe = w_sa.qe;
        n_p_side.brem = w_bdiff[BPM_REM_W-1:0];
    end

    // prep register between the chains
    logic                           r_p_valid;
    logic [LANES-1:0][DEN_B_W-1:0]  r_p_rem;
    logic [LANES-1:0][STEPS_B-1:0]  r_p_num;
    logic [LANES-1:0][DEN_B_W-1:0]  r_p_den;
    t_side_b                        r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_adv) begin
            r_p_valid <= w_ao_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_rem <= n_p_rem;
            r_p_num <= n_p_num;
            r_p_den <= n_p_den;
            r_p_side <= n_p_side;
        end
    end

    logic                           w_bo_valid;
    logic [LANES-1:0][DEN_B_W-1:0]  w_bo_rem;
    logic [LANES-1:0][STEPS_B-1:0]  w_bo_quo;
    logic [LANES-1:0][DEN_B_W-1:0]  w_bo_den;
    logic [SIDE_B_W-1:0]            w_bo_side;
    t_side_b                        w_sb;

    bds_div_chain #(
        .STEPS(STEPS_B),
        .DEN_W(DEN_B_W),
        .SIDE_W(SIDE_B_W)
    ) u_chain_b (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(w_adv),
        .i_valid(r_p_valid),
        .i_rem(r_p_rem),
        .i_num(r_p_num),
        .i_den(r_p_den),
        .i_side(r_p_side),
        .o_valid(w_bo_valid),
        .o_rem(w_bo_rem),
        .o_quo(w_bo_quo),
        .o_den(w_bo_den),
        .o_side(w_bo_side)
    );

    assign w_sb = t_side_b'(w_bo_side);

    // selection and characters per ms
    logic           w_use4;
    logic [9:0]     w_bpm;
    logic [1:0]     n_port;
    logic [7:0]     n_div;
    logic           n_hs;
    logic [8:0]     n_bpm;
    logic           n_rerr;

    always_comb begin
        w_use4 = w_sb.fit4 && !w_sb.neg4
                 && (w_sb.neg16 || (w_bo_quo[LANE_X4] < w_bo_quo[LANE_X16]));
        w_bpm = w_sb.qe + ((w_sb.brem >= BPM_REM_W'(BPM_DIV)) ? 10'd1 : 10'd0);
        n_port = w_sb.port;
        if (w_sb.zero) begin
            n_div = 8'd0;
            n_hs = 1'b0;
            n_bpm = 9'd1;
            n_rerr = 1'b1;
        end else begin
            n_div = w_use4 ? w_sb.d4 : w_sb.d16;
            n_hs = w_use4;
            n_bpm = (w_bpm == '0) ? 9'd1 : w_bpm[8:0];
            n_rerr = w_sb.neg4 || w_sb.neg16;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_bo_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_port_tag <= n_port;
            o_divisor <= n_div;
            o_high_speed <= n_hs;
            o_chars_per_ms <= n_bpm;
            o_range_error <= n_rerr;
        end
    end

    // checks
    a_bpm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_chars_per_ms != 9'd0))
        else $error("chars_per_ms is zero");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s0_valid)
        else $error("accepted transfer not captured");

endmodule

`default_nettype wire

[test/baud_divisor_selector_test.sv]
`timescale 1ns / 1ps

module baud_divisor_selector_test;
    import bds_pkg::*;

    typedef struct packed {
        logic [1:0] port_tag;
        logic [7:0] divisor;
        logic       high_speed;
        logic [8:0] chars_per_ms;
        logic       range_error;
    } t_setting;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CLK_W-1:0]  i_cfg_wr_data;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_port_number;
    logic [BAUD_W-1:0] i_baud_rate;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_port_tag;
    logic [7:0]        o_divisor;
    logic              o_high_speed;
    logic [8:0]        o_chars_per_ms;
    logic              o_range_error;

    t_setting          pending_settings[$];
    logic [CLK_W-1:0]  model_clock_hz;
    int                mismatch_count;
    int                setting_count;
    int                sent_count;
    int                send_idle_pct;
    int                stall_pct;
    int                hold_cycles;

    baud_divisor_selector uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_port_number(i_port_number), .i_baud_rate(i_baud_rate),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_port_tag(o_port_tag), .o_divisor(o_divisor), .o_high_speed(o_high_speed),
        .o_chars_per_ms(o_chars_per_ms), .o_range_error(o_range_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // absolute permille error of one candidate divisor
    function automatic longint rate_error(longint clk, longint baud, longint m, longint d);
        longint den;
        longint e;
        den = m * baud * (d + 1);
        e = ((clk - den) * 1000) / den;
        return (e < 0) ? -e : e;
    endfunction

    // expected setting for one request
    function automatic t_setting pick_divisor(logic [1:0] port, logic [BAUD_W-1:0] baud_in);
        t_setting s;
        longint clk;
        longint baud;
        longint d4;
        longint d16;
        longint bpm;
        bit use4;
        clk = model_clock_hz;
        baud = baud_in;
        s = '0;
        s.port_tag = port;
        s.chars_per_ms = 9'd1;
        use4 = 1'b0;
        if (baud == 0) begin
            s.range_error = 1'b1;
        end else begin
            d4 = (clk + 2 * baud) / (4 * baud) - 1;
            d16 = (clk + 8 * baud) / (16 * baud) - 1;
            s.range_error = (d4 < 0 || d16 < 0);
            if (d4 >= 0 && d4 <= 255) begin
                if (d16 < 0)
                    use4 = 1'b1;
                else
                    use4 = rate_error(clk, baud, 4, d4) < rate_error(clk, baud, 16, d16);
            end
            s.divisor = use4 ? d4[7:0] : d16[7:0];
            s.high_speed = use4;
            bpm = (baud + 5000) / 10000;
            s.chars_per_ms = (bpm == 0) ? 9'd1 : bpm[8:0];
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // send one request, holding it until the transfer
    task automatic send_request(logic [1:0] port, logic [BAUD_W-1:0] baud);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_port_number <= port;
        i_baud_rate <= baud;
        pending_settings.push_back(pick_divisor(port, baud));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    // stop offering, wait until all results are back, then for longer than the pipeline depth
    task automatic drain;
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_settings.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        model_clock_hz = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // random baud rate, mostly in usual ranges
    function automatic logic [BAUD_W-1:0] random_baud();
        case ($urandom_range(5))
            0: return BAUD_W'($urandom_range(4000000, 0));
            1: return BAUD_W'($urandom_range(300, 1));
            2: return BAUD_W'($urandom_range(115200, 1200));
            3: return BAUD_W'($urandom_range(4194303, 0));
            default: return BAUD_W'($urandom_range(20000, 1));
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin : p_check
        t_setting want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_settings.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_settings.pop_front();
                setting_count++;
                if (o_port_tag != want.port_tag)
                    report_mismatch("port_tag", o_port_tag, want.port_tag);
                if (o_divisor != want.divisor)
                    report_mismatch("divisor", o_divisor, want.divisor);
                if (o_high_speed != want.high_speed)
                    report_mismatch("high_speed", o_high_speed, want.high_speed);
                if (o_chars_per_ms != want.chars_per_ms)
                    report_mismatch("chars_per_ms", o_chars_per_ms, want.chars_per_ms);
                if (o_range_error != want.range_error)
                    report_mismatch("range_error", o_range_error, want.range_error);
            end
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic test_directed;
        send_request(2'd0, 22'd0);
        send_request(2'd3, 22'd4194303);
        send_request(2'd1, 22'd1);
        send_request(2'd2, 22'd9600);
        send_request(2'd0, 22'd115200);
        send_request(2'd1, 22'd4000000);
        send_request(2'd2, 22'd1000000);
        send_request(2'd3, 22'd2999999);
        send_request(2'd0, 22'd4999);
        send_request(2'd1, 22'd5000);
        send_request(2'd2, 22'd300);
        send_request(2'd3, 22'd15625);
        send_request(2'd0, 22'd2796202);
        write_clock(28'd0);
        send_request(2'd1, 22'd9600);
        send_request(2'd2, 22'd1);
        write_clock(28'hFFFFFFF);
        send_request(2'd3, 22'd1);
        send_request(2'd0, 22'd9600);
        send_request(2'd1, 22'd4194303);
        write_clock(28'd1);
        send_request(2'd2, 22'd1);
        send_request(2'd3, 22'd2);
        write_clock(28'd200000000);
        send_request(2'd0, 22'd1);
        send_request(2'd1, 22'd3000000);
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (count) send_request(2'($urandom), random_baud());
    endtask

    task automatic test_clock_settings;
        logic [CLK_W-1:0] clocks[5];
        clocks = '{28'd16000000, 28'd1843200, 28'd40000000, 28'($urandom), 28'd9999};
        foreach (clocks[k]) begin
            write_clock(clocks[k]);
            test_random(20, 0, 0);
        end
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        repeat (80) send_request(2'($urandom), random_baud());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_valid = 1'b0;
        i_port_number = '0;
        i_baud_rate = '0;
        i_stall = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        setting_count = 0;
        sent_count = 0;
        model_clock_hz = CLK_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_clock(CLK_RESET);
        test_random(120, 0, 0);
        test_random(100, 84, 0);
        test_random(100, 0, 84);
        test_random(100, 11, 11);
        test_clock_settings();
        test_backpressure();
        drain();
        $display("covered %0d requests, %0d settings checked, clock from 0 to max",
                 sent_count, setting_count);
        $display("idle and stall phases plus a long receiver hold-off were exercised");
        if (mismatch_count == 0 && pending_settings.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
